/* src/ttb_pkg.sv */
// Package for the turn timer bank: request, result and slot entry types and command codes.
package ttb_pkg;

   localparam int DEFAULT_NUM_SLOTS = 16;
   localparam int MAX_RESULTS       = 16;
   localparam int TURN_WIDTH        = 32;
   localparam int RATE_WIDTH        = 16;

   localparam logic [2:0] CMD_TICK      = 3'd0;
   localparam logic [2:0] CMD_SET       = 3'd1;
   localparam logic [2:0] CMD_CLEAR     = 3'd2;
   localparam logic [2:0] CMD_QUERY     = 3'd3;
   localparam logic [2:0] CMD_CLEAR_ALL = 3'd4;

   typedef struct packed {
      logic [2:0]            command;
      logic [3:0]            slot;
      logic [RATE_WIDTH-1:0] rate;
      logic                  loop;
      logic [RATE_WIDTH-1:0] first_delay;
      logic                  first_delay_given;
   } ttb_req_type;

   typedef struct packed {
      logic                  fired;
      logic [3:0]            fired_slot;
      logic                  last;
      logic                  exists;
      logic [RATE_WIDTH-1:0] remaining;
      logic [TURN_WIDTH-1:0] current_turn;
   } ttb_rsp_type;

   typedef struct packed {
      logic                  loops;
      logic [RATE_WIDTH-1:0] period;
      logic [TURN_WIDTH-1:0] expiry;
   } ttb_entry_type;

   localparam int ENTRY_WIDTH = $bits(ttb_entry_type);

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic tick_go;
      logic query_go;
      logic simple_go;
      logic scan;
      logic finish;
      logic query_out;
   } ttb_cmd_type;

endpackage

/* src/ttb_ram.sv */
// Generic simple dual-port RAM with one write port and one registered read port.
module ttb_ram import ttb_pkg::*; #(
   parameter int WIDTH = ENTRY_WIDTH,
   parameter int DEPTH = DEFAULT_NUM_SLOTS
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/ttb_ctrl.sv */
// Controller state machine of the turn timer bank: sequences ticks, queries and simple requests.
module ttb_ctrl import ttb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [2:0]  command,
   input  logic        scan_last,
   output logic        busy,
   output ttb_cmd_type cmd
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_FINISH = 4'b0100,
      ST_QUERY  = 4'b1000
   } ttb_state_type;

   ttb_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               case (command)
                  CMD_TICK: begin
                     cmd.tick_go = 1'b1;
                     state_in    = ST_SCAN;
                  end
                  CMD_QUERY: begin
                     cmd.query_go = 1'b1;
                     state_in     = ST_QUERY;
                  end
                  default: begin
                     cmd.simple_go = 1'b1;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (scan_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = ST_IDLE;
         end
         ST_QUERY: begin
            cmd.query_out = 1'b1;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* src/ttb_dp.sv */
// Datapath of the turn timer bank: turn counter, active bits, slot RAM, scan and result register.
module ttb_dp import ttb_pkg::*; #(
   parameter int NUM_SLOTS = DEFAULT_NUM_SLOTS
) (
   input  logic        clock,
   input  logic        reset,
   input  ttb_req_type req_data,
   input  ttb_cmd_type cmd,
   output logic        scan_last,
   output logic        rsp_strobe,
   output ttb_rsp_type rsp_data
);

   localparam int IW = NUM_SLOTS > 1 ? $clog2(NUM_SLOTS) : 1;
   localparam logic [6:0] SLOT_LIMIT = 7'(NUM_SLOTS);

   logic [TURN_WIDTH-1:0] turn_ff, turn_in;
   logic [NUM_SLOTS-1:0]  active_ff, active_in;
   logic [IW-1:0]         idx_ff, idx_in;
   logic                  pend_valid_ff, pend_valid_in;
   logic [3:0]            pend_slot_ff, pend_slot_in;
   logic [4:0]            fire_cnt_ff, fire_cnt_in;
   logic                  q_exists_ff, q_exists_in;
   ttb_rsp_type           rsp_ff, rsp_in;
   logic                  rsp_strobe_ff, rsp_strobe_in;

   logic                  wr_en;
   logic [IW-1:0]         wr_addr;
   ttb_entry_type         wr_data;
   logic [IW-1:0]         rd_addr;
   ttb_entry_type         rd_data;

   logic [6:0]            slot_ext;
   logic [IW-1:0]         slot_idx;
   logic                  in_range;
   logic [TURN_WIDTH-1:0] diff;
   logic                  due;
   logic                  fire;
   logic                  report;
   ttb_rsp_type           rsp_plain;

   assign slot_ext  = {3'b000, req_data.slot};
   assign slot_idx  = slot_ext[IW-1:0];
   assign in_range  = slot_ext < SLOT_LIMIT;
   assign scan_last = idx_ff == IW'(NUM_SLOTS - 1);

   // Wrapping difference: the slot is due when expiry minus turn is zero or negative.
   assign diff   = rd_data.expiry - turn_ff;
   assign due    = (diff == '0) || diff[TURN_WIDTH-1];
   assign fire   = cmd.scan && active_ff[idx_ff] && due;
   assign report = fire && (fire_cnt_ff < 5'(MAX_RESULTS));

   assign rd_addr = cmd.scan ? idx_ff + IW'(1) : (cmd.tick_go ? '0 : slot_idx);

   always_comb begin
      rsp_plain              = '0;
      rsp_plain.last         = 1'b1;
      rsp_plain.current_turn = turn_ff;

      turn_in        = turn_ff;
      active_in      = active_ff;
      idx_in         = idx_ff;
      pend_valid_in  = pend_valid_ff;
      pend_slot_in   = pend_slot_ff;
      fire_cnt_in    = fire_cnt_ff;
      q_exists_in    = q_exists_ff;
      rsp_in         = rsp_ff;
      rsp_strobe_in  = 1'b0;
      wr_en          = 1'b0;
      wr_addr        = slot_idx;
      wr_data.loops  = req_data.loop;
      wr_data.period = req_data.rate;
      wr_data.expiry = turn_ff + TURN_WIDTH'(req_data.first_delay_given ?
                                             req_data.first_delay : req_data.rate);

      if (cmd.simple_go) begin
         case (req_data.command)
            CMD_SET: begin
               if (in_range) begin
                  active_in[slot_idx] = req_data.rate != '0;
                  wr_en               = req_data.rate != '0;
               end
            end
            CMD_CLEAR: begin
               if (in_range) begin
                  active_in[slot_idx] = 1'b0;
               end
            end
            CMD_CLEAR_ALL: begin
               active_in = '0;
               turn_in   = '0;
            end
            default: begin
            end
         endcase
         rsp_in              = rsp_plain;
         rsp_in.current_turn = turn_in;
         rsp_strobe_in       = 1'b1;
      end

      if (cmd.tick_go) begin
         turn_in       = turn_ff + TURN_WIDTH'(1);
         idx_in        = '0;
         pend_valid_in = 1'b0;
         fire_cnt_in   = '0;
      end

      if (cmd.query_go) begin
         q_exists_in = in_range && active_ff[slot_idx];
      end

      if (cmd.scan) begin
         idx_in = idx_ff + IW'(1);
         if (fire) begin
            if (rd_data.loops) begin
               wr_en          = 1'b1;
               wr_addr        = idx_ff;
               wr_data        = rd_data;
               wr_data.expiry = turn_ff + TURN_WIDTH'(rd_data.period);
            end else begin
               active_in[idx_ff] = 1'b0;
            end
         end
         // A reported slot is held back until the next report or the finish so that the final one can carry last.
         if (report) begin
            if (pend_valid_ff) begin
               rsp_in            = rsp_plain;
               rsp_in.fired      = 1'b1;
               rsp_in.fired_slot = pend_slot_ff;
               rsp_in.last       = 1'b0;
               rsp_strobe_in     = 1'b1;
            end
            pend_valid_in = 1'b1;
            pend_slot_in  = 4'(idx_ff);
            fire_cnt_in   = fire_cnt_ff + 5'd1;
         end
      end

      if (cmd.finish) begin
         rsp_in            = rsp_plain;
         rsp_in.fired      = pend_valid_ff;
         rsp_in.fired_slot = pend_valid_ff ? pend_slot_ff : 4'd0;
         rsp_strobe_in     = 1'b1;
      end

      if (cmd.query_out) begin
         rsp_in        = rsp_plain;
         rsp_in.exists = q_exists_ff;
         if (!q_exists_ff || diff[TURN_WIDTH-1]) begin
            rsp_in.remaining = '0;
         end else if (diff[TURN_WIDTH-1:RATE_WIDTH] != '0) begin
            rsp_in.remaining = '1;
         end else begin
            rsp_in.remaining = diff[RATE_WIDTH-1:0];
         end
         rsp_strobe_in = 1'b1;
      end
   end

   ttb_ram #(
      .WIDTH(ENTRY_WIDTH),
      .DEPTH(NUM_SLOTS)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         turn_ff       <= '0;
         active_ff     <= '0;
         pend_valid_ff <= 1'b0;
         fire_cnt_ff   <= '0;
         idx_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         turn_ff       <= turn_in;
         active_ff     <= active_in;
         pend_valid_ff <= pend_valid_in;
         fire_cnt_ff   <= fire_cnt_in;
         idx_ff        <= idx_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_slot_ff <= pend_slot_in;
      q_exists_ff  <= q_exists_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

/* src/turn_timer_bank_top.sv */
// Top level of the turn timer bank: controller, datapath and interface assertions.
//
// A request is taken at a rising edge where start is high and busy is low; its fields
// arrive in req_data. Each result appears in rsp_data for one cycle with rsp_strobe
// high, and the receiver has no means to hold it off.
// Set, clear, clear all and unknown requests leave busy low and give one result in
// the cycle after acceptance, so one may be issued in every cycle.
// A query reads the slot RAM through its registered read port and registers the result in
// the query state; busy is high for one cycle.
// A tick keeps busy high through the scan and finish states: the scan reads one slot per
// cycle from the slot RAM and rearms or frees each slot that expires. Fired slots come out
// in ascending order, each registered when the next fire is found, and the final result,
// marked by last, is registered in the finish state and carries the last reported slot.
// A tick with nothing due gives a single result with fired low.
// Reset clears the turn counter and every active bit at once; no clearing pass is
// needed, and a request may be issued in the first cycle after reset.
module turn_timer_bank_top import ttb_pkg::*; #(
   parameter int NUM_SLOTS = DEFAULT_NUM_SLOTS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  ttb_req_type req_data,
   output logic        rsp_strobe,
   output ttb_rsp_type rsp_data
);

   ttb_cmd_type cmd;
   logic        scan_last;

   ttb_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .command  (req_data.command),
      .scan_last(scan_last),
      .busy     (busy),
      .cmd      (cmd)
   );

   ttb_dp #(
      .NUM_SLOTS(NUM_SLOTS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .scan_last (scan_last),
      .rsp_strobe(rsp_strobe),
      .rsp_data  (rsp_data)
   );

   // A simple request is answered in the very next cycle with a single final result.
   assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_data.command != CMD_TICK && req_data.command != CMD_QUERY
      |=> rsp_strobe && rsp_data.last)
      else $error("simple request not answered in the next cycle");

   // A query result, final and not fired, follows acceptance.
   assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_data.command == CMD_QUERY
      |-> ##2 (rsp_strobe && rsp_data.last && !rsp_data.fired))
      else $error("query result missing");

   // Results that are not final only come out as fires while a tick still holds busy high.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.last |-> busy && rsp_data.fired)
      else $error("non-final result outside a tick scan");

   // Only a fired result names a slot.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.fired |-> rsp_data.fired_slot == 4'd0)
      else $error("slot reported without a fire");

endmodule
